/* design/nme_pkg.sv */
// Package for the neighbour MLP mean encoder: widths, weight ROMs and shared types.
package nme_pkg;

  localparam int InFeatures  = 6;
  localparam int HiddenUnits = 8;
  localparam int EmbedSize   = 8;
  localparam int FracShift   = 14;
  localparam int RoundHalf   = 8192;
  localparam int MeanScale   = 2731;
  localparam int AccW        = 42;
  localparam int SumW        = 24;

  typedef logic signed [15:0] w_t;
  typedef logic signed [AccW-1:0] acc_t;

  typedef struct packed {
    logic signed [15:0] rel_pos_x;
    logic signed [15:0] rel_pos_y;
    logic signed [15:0] rel_pos_z;
    logic signed [15:0] rel_vel_x;
    logic signed [15:0] rel_vel_y;
    logic signed [15:0] rel_vel_z;
    logic               last_neighbor;
  } in_item_t;

  typedef struct packed {
    logic [15:0] emb_0;
    logic [15:0] emb_1;
    logic [15:0] emb_2;
    logic [15:0] emb_3;
    logic [15:0] emb_4;
    logic [15:0] emb_5;
    logic [15:0] emb_6;
    logic [15:0] emb_7;
  } out_item_t;

  // Control from the sequencer to the MAC datapath.
  typedef struct packed {
    logic       load_bias;
    logic       mac;
    logic [2:0] row;
    logic [2:0] col;
    logic       layer_b;
  } mac_ctrl_t;

  function automatic w_t wa(input logic [2:0] r, input logic [2:0] c);
    logic [6:0] i;
    w_t v;
    i = {1'b0, r, 3'b000} - {3'b000, r, 1'b0} + {4'b0000, c}; // r*6 + c
    case (i)
      7'd0: v = 16'sd8875;   7'd1: v = -16'sd11131; 7'd2: v = -16'sd10520;
      7'd3: v = 16'sd1508;   7'd4: v = -16'sd3891;  7'd5: v = -16'sd2269;
      7'd6: v = 16'sd8531;   7'd7: v = -16'sd11593; 7'd8: v = -16'sd7021;
      7'd9: v = -16'sd2093;  7'd10: v = 16'sd5559;  7'd11: v = -16'sd3138;
      7'd12: v = 16'sd7548;  7'd13: v = -16'sd9862; 7'd14: v = -16'sd6108;
      7'd15: v = -16'sd6173; 7'd16: v = 16'sd7427;  7'd17: v = 16'sd4243;
      7'd18: v = 16'sd8874;  7'd19: v = -16'sd9398; 7'd20: v = 16'sd1346;
      7'd21: v = -16'sd7363; 7'd22: v = 16'sd7329;  7'd23: v = 16'sd97;
      7'd24: v = -16'sd501;  7'd25: v = -16'sd2177; 7'd26: v = 16'sd2264;
      7'd27: v = 16'sd2753;  7'd28: v = -16'sd614;  7'd29: v = -16'sd5649;
      7'd30: v = -16'sd6747; 7'd31: v = 16'sd5335;  7'd32: v = 16'sd4370;
      7'd33: v = -16'sd6709; 7'd34: v = -16'sd1635; 7'd35: v = -16'sd3595;
      7'd36: v = 16'sd13488; 7'd37: v = -16'sd3215; 7'd38: v = 16'sd2083;
      7'd39: v = -16'sd2584; 7'd40: v = -16'sd4277; 7'd41: v = 16'sd4363;
      7'd42: v = 16'sd5624;  7'd43: v = -16'sd6169; 7'd44: v = -16'sd12927;
      7'd45: v = 16'sd1402;  7'd46: v = 16'sd3621;  7'd47: v = 16'sd3602;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic w_t wb(input logic [2:0] r, input logic [2:0] c);
    logic [5:0] i;
    w_t v;
    i = {r, c};
    case (i)
      6'd0: v = -16'sd533;    6'd1: v = -16'sd6248;   6'd2: v = 16'sd3994;
      6'd3: v = -16'sd5030;   6'd4: v = -16'sd2856;   6'd5: v = 16'sd5864;
      6'd6: v = 16'sd4803;    6'd7: v = -16'sd2173;
      6'd8: v = 16'sd21;      6'd9: v = 16'sd3662;    6'd10: v = 16'sd5553;
      6'd11: v = -16'sd9950;  6'd12: v = 16'sd5620;   6'd13: v = -16'sd11234;
      6'd14: v = -16'sd19236; 6'd15: v = -16'sd5499;
      6'd16: v = -16'sd13849; 6'd17: v = -16'sd9920;  6'd18: v = -16'sd9755;
      6'd19: v = 16'sd661;    6'd20: v = -16'sd3478;  6'd21: v = -16'sd4438;
      6'd22: v = -16'sd3318;  6'd23: v = 16'sd4393;
      6'd24: v = 16'sd5064;   6'd25: v = 16'sd2421;   6'd26: v = -16'sd9314;
      6'd27: v = 16'sd6321;   6'd28: v = -16'sd2158;  6'd29: v = 16'sd8898;
      6'd30: v = -16'sd3884;  6'd31: v = -16'sd8705;
      6'd32: v = -16'sd9693;  6'd33: v = 16'sd524;    6'd34: v = 16'sd6591;
      6'd35: v = 16'sd6773;   6'd36: v = -16'sd375;   6'd37: v = -16'sd283;
      6'd38: v = -16'sd4000;  6'd39: v = -16'sd7637;
      6'd40: v = -16'sd1293;  6'd41: v = 16'sd6107;   6'd42: v = 16'sd7517;
      6'd43: v = -16'sd4868;  6'd44: v = 16'sd9332;   6'd45: v = -16'sd3894;
      6'd46: v = -16'sd3047;  6'd47: v = -16'sd13764;
      6'd48: v = -16'sd12648; 6'd49: v = -16'sd8497;  6'd50: v = 16'sd8987;
      6'd51: v = -16'sd2974;  6'd52: v = 16'sd7430;   6'd53: v = -16'sd1306;
      6'd54: v = -16'sd1235;  6'd55: v = -16'sd2633;
      6'd56: v = -16'sd13395; 6'd57: v = -16'sd3403;  6'd58: v = 16'sd5982;
      6'd59: v = 16'sd3148;   6'd60: v = -16'sd12;    6'd61: v = 16'sd746;
      6'd62: v = -16'sd2808;  6'd63: v = -16'sd7310;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic w_t ba(input logic [2:0] r);
    w_t v;
    case (r)
      3'd0: v = 16'sd1483;  3'd1: v = 16'sd2490; 3'd2: v = -16'sd1910;
      3'd3: v = 16'sd360;   3'd4: v = 16'sd3465; 3'd5: v = 16'sd569;
      3'd6: v = 16'sd1770;  3'd7: v = 16'sd2416;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic w_t bb(input logic [2:0] r);
    w_t v;
    case (r)
      3'd0: v = 16'sd3421;  3'd1: v = 16'sd4002; 3'd2: v = 16'sd4554;
      3'd3: v = 16'sd2450;  3'd4: v = -16'sd236; 3'd5: v = 16'sd1934;
      3'd6: v = 16'sd3073;  3'd7: v = 16'sd4409;
      default: v = '0;
    endcase
    return v;
  endfunction

  // ReLU, round to Q8.8 and saturate.
  function automatic logic [15:0] relu_round(input acc_t a);
    logic [AccW-1:0] u;
    logic [15:0] r;
    u = a + acc_t'(RoundHalf);
    if (a <= 0) r = '0;
    else if (|u[AccW-1:FracShift+16]) r = 16'hFFFF;
    else r = u[FracShift+15:FracShift];
    return r;
  endfunction

endpackage

/* design/nme_if.sv */
// Valid/ready channel interface carrying one payload.
interface nme_if #(type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/nme_mac.sv */
// Shared multiply-accumulate datapath with hidden-unit registers and input feature selection.
module nme_mac (
  input  logic                  clk,
  input  nme_pkg::mac_ctrl_t    ctrl,
  input  nme_pkg::in_item_t     item,
  input  logic                  store_hid,
  output nme_pkg::acc_t         acc
);
  logic [15:0] hid [nme_pkg::HiddenUnits];
  logic signed [16:0] x;
  nme_pkg::w_t w;
  logic signed [32:0] prod;

  always_comb begin
    x = '0;
    if (ctrl.layer_b) begin
      x = $signed({1'b0, hid[ctrl.col]});
      w = nme_pkg::wb(ctrl.row, ctrl.col);
    end else begin
      w = nme_pkg::wa(ctrl.row, ctrl.col);
      case (ctrl.col)
        3'd0: x = 17'(item.rel_pos_x);
        3'd1: x = 17'(item.rel_pos_y);
        3'd2: x = 17'(item.rel_pos_z);
        3'd3: x = 17'(item.rel_vel_x);
        3'd4: x = 17'(item.rel_vel_y);
        3'd5: x = 17'(item.rel_vel_z);
        default: x = '0;
      endcase
    end
    prod = w * x;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_bias) begin
      acc <= ctrl.layer_b ? nme_pkg::acc_t'(nme_pkg::bb(ctrl.row)) <<< 8
                          : nme_pkg::acc_t'(nme_pkg::ba(ctrl.row)) <<< 8;
    end else if (ctrl.mac) begin
      acc <= acc + nme_pkg::acc_t'(prod);
    end
    if (store_hid) hid[ctrl.row] <= nme_pkg::relu_round(acc);
  end
endmodule

/* design/neighbor_mlp_mean_encoder_unit.sv */
// Top level of the neighbour MLP mean encoder: sequencer, pooling sums and output register.
//
// Usage: one neighbour observation is a transfer on the input channel (six signed
// Q8.8 values and a last flag). The block then runs both dense layers on a single
// shared multiply-accumulate unit, one product per cycle: each of the 16 neurons
// has a bias step, its products (6 or 8) and a rounding step; input ready stays
// low while the item is processed. Every item adds its eight features into
// saturating 24-bit sums. On the item flagged last, the sums are scaled by 1/6,
// one multiply a cycle unless a stalled earlier result holds the output register, then
// written to the output register as one result transfer, and cleared.
// A result waits in the output register while the receiver stalls; the next item
// is still accepted, and its own result waits only if the register is still full.
// Reset clears the sums, the sequencer and the output valid.
module neighbor_mlp_mean_encoder_unit (
  input logic clk,
  input logic rst,
  nme_if.sink   in_ch,
  nme_if.source out_ch
);
  typedef enum logic [2:0] {IDLE, BIAS, MAC, STORE, SCALE, EMIT} state_t;
  state_t state;
  nme_pkg::in_item_t item;
  nme_pkg::mac_ctrl_t ctrl;
  nme_pkg::acc_t acc;
  logic [2:0] row, col;
  logic layer_b, last;
  logic [nme_pkg::SumW-1:0] sums [nme_pkg::EmbedSize];
  logic [15:0] emb [nme_pkg::EmbedSize];
  logic [15:0] feat;
  logic [nme_pkg::SumW:0] sum_next;
  logic [nme_pkg::SumW+11:0] scaled;
  logic [2:0] ncols;

  assign ncols = layer_b ? 3'd7 : 3'd5;
  assign ctrl = '{load_bias: state == BIAS, mac: state == MAC, row: row,
                  col: col, layer_b: layer_b};
  assign feat = nme_pkg::relu_round(acc);
  assign sum_next = {1'b0, sums[row]} + (nme_pkg::SumW+1)'(feat);
  assign scaled = sums[row] * 12'(nme_pkg::MeanScale)
                  + (nme_pkg::SumW+12)'(nme_pkg::RoundHalf);

  nme_mac u_mac (.clk(clk), .ctrl(ctrl), .item(item),
                 .store_hid(state == STORE && !layer_b), .acc(acc));

  assign in_ch.ready = (state == IDLE);
  assign out_ch.data = '{emb_0: emb[0], emb_1: emb[1], emb_2: emb[2], emb_3: emb[3],
                         emb_4: emb[4], emb_5: emb[5], emb_6: emb[6], emb_7: emb[7]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      out_ch.valid <= 1'b0;
      row <= '0; col <= '0; layer_b <= 1'b0; last <= 1'b0;
      for (int i = 0; i < nme_pkg::EmbedSize; i++) sums[i] <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        IDLE: begin
          if (in_ch.valid) begin
            item <= in_ch.data;
            last <= in_ch.data.last_neighbor;
            row <= '0; col <= '0; layer_b <= 1'b0;
            state <= BIAS;
          end
        end
        BIAS: state <= MAC;
        MAC: begin
          if (col == ncols) begin
            col <= '0;
            state <= STORE;
          end else col <= col + 3'd1;
        end
        STORE: begin
          if (layer_b)
            sums[row] <= sum_next[nme_pkg::SumW] ? '1 : sum_next[nme_pkg::SumW-1:0];
          row <= row + 3'd1;
          state <= BIAS;
          if (row == 3'd7) begin
            if (!layer_b) layer_b <= 1'b1;
            else if (last) state <= SCALE;
            else state <= IDLE;
          end
        end
        SCALE: begin
          // Hold off while an earlier result is still waiting.
          if (!out_ch.valid || out_ch.ready) begin
            emb[row] <= (|scaled[nme_pkg::SumW+11:nme_pkg::FracShift+16]) ? 16'hFFFF
                        : scaled[nme_pkg::FracShift+15:nme_pkg::FracShift];
            sums[row] <= '0;
            row <= row + 3'd1;
            if (row == 3'd7) state <= EMIT;
          end
        end
        EMIT: begin
          out_ch.valid <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != IDLE |-> !in_ch.ready) else $error("input ready while busy");
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    state == EMIT |=> out_ch.valid) else $error("result not presented");
  a_scale_only_last: assert property (@(posedge clk) disable iff (rst)
    state == SCALE |-> last) else $error("scaling without last item");
endmodule
